[rtl/svpm_pkg.sv]
// Shared types and constants of the phase duty modulator.
package svpm_pkg;

    typedef logic signed [15:0] t_cmd;
    typedef logic signed [16:0] t_q15;
    typedef logic signed [17:0] t_volt;
    typedef logic [15:0]        t_u16;

    typedef enum logic [7:0] {
        REG_SUPPLY = 8'd0,
        REG_PERIOD = 8'd1
    } t_reg_idx;

    localparam t_u16 SUPPLY_RST = 16'd3072;
    localparam t_u16 PERIOD_RST = 16'd1000;

    localparam int SIN_STAGES  = 8;
    localparam int SQRT_STAGES = 10;
    localparam int MIX_STAGES  = 6;
    localparam int DUTY_STAGES = 9;

    // quarter-wave sine polynomial, Q28
    localparam logic [28:0] SIN_C1 = 29'd421657428;
    localparam logic [28:0] SIN_C3 = 29'd173399667;
    localparam logic [28:0] SIN_C5 = 29'd21392326;
    localparam logic [28:0] SIN_C7 = 29'd1256749;
    localparam logic [28:0] SIN_C9 = 29'd43068;

    localparam logic signed [17:0] SQRT3_Q16  = 18'sd113512;
    // ceil(2^21 / 3), exact floor(x / 3) for x < 2^21
    localparam logic [19:0]        DIV3_RECIP = 20'd699051;

endpackage

[rtl/svpm_sine.sv]
// Pipelined Q15 sine of a 32-bit turn fraction (quarter-wave polynomial).
module svpm_sine (
    input  logic                      i_clk,
    input  logic [svpm_pkg::SIN_STAGES-1:0] i_en,
    input  logic [31:0]               i_turn,
    output svpm_pkg::t_q15            o_sine
);
    import svpm_pkg::*;

    logic [16:0] r_fd   [1:6];
    logic        r_negd [1:7];
    logic [16:0] r_x2d  [2:5];
    logic [28:0] r_p    [3:6];
    logic [29:0] r_s;
    t_q15        r_out;

    logic [16:0] f_in;
    logic [33:0] sq;
    logic [45:0] m3, m4, m5, m6, m7;
    logic [30:0] rsum;
    logic [17:0] rr;

    always_comb begin
        f_in = i_turn[30] ? (17'd65536 - {1'b0, i_turn[29:14]}) : {1'b0, i_turn[29:14]};
        sq   = 34'(r_fd[1]) * 34'(r_fd[1]);
        m3   = 46'(SIN_C9) * 46'(r_x2d[2]);
        m4   = 46'(r_p[3]) * 46'(r_x2d[3]);
        m5   = 46'(r_p[4]) * 46'(r_x2d[4]);
        m6   = 46'(r_p[5]) * 46'(r_x2d[5]);
        m7   = 46'(r_p[6]) * 46'(r_fd[6]);
        rsum = 31'(r_s) + 31'd4096;
        rr   = 18'(rsum >> 13);
        if (rr > 18'd32768) begin
            rr = 18'd32768;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_fd[1]   <= f_in;
            r_negd[1] <= i_turn[31];
        end
        for (int k = 2; k <= 6; k++) begin
            if (i_en[k-1]) begin
                r_fd[k] <= r_fd[k-1];
            end
        end
        for (int k = 2; k <= 7; k++) begin
            if (i_en[k-1]) begin
                r_negd[k] <= r_negd[k-1];
            end
        end
        if (i_en[1]) begin
            r_x2d[2] <= sq[32:16];
        end
        for (int k = 3; k <= 5; k++) begin
            if (i_en[k-1]) begin
                r_x2d[k] <= r_x2d[k-1];
            end
        end
        if (i_en[2]) begin
            r_p[3] <= SIN_C7 - 29'(m3 >> 16);
        end
        if (i_en[3]) begin
            r_p[4] <= SIN_C5 - 29'(m4 >> 16);
        end
        if (i_en[4]) begin
            r_p[5] <= SIN_C3 - 29'(m5 >> 16);
        end
        if (i_en[5]) begin
            r_p[6] <= SIN_C1 - 29'(m6 >> 16);
        end
        if (i_en[6]) begin
            r_s <= 30'(m7 >> 16);
        end
        if (i_en[7]) begin
            r_out <= r_negd[7] ? -$signed({1'b0, rr[15:0]}) - $signed(17'(rr[16]) <<< 16)
                               : $signed(17'(rr));
        end
    end

    assign o_sine = r_out;

endmodule

[rtl/svpm_isqrt.sv]
// Pipelined floor(sqrt(q^2 + d^2)), two result bits per stage.
module svpm_isqrt (
    input  logic                             i_clk,
    input  logic [svpm_pkg::SQRT_STAGES-1:0] i_en,
    input  svpm_pkg::t_cmd                   i_vq,
    input  svpm_pkg::t_cmd                   i_vd,
    output logic [15:0]                      o_mag
);
    import svpm_pkg::*;

    typedef struct packed {
        logic [31:0] n;
        logic [31:0] res;
    } t_sq;

    function automatic t_sq sq_step(t_sq x, int k);
        t_sq         y;
        logic [31:0] bval;
        logic [31:0] trial;
        bval  = 32'd1 << (30 - 2 * k);
        trial = x.res + bval;
        y     = x;
        if (x.n >= trial) begin
            y.n   = x.n - trial;
            y.res = (x.res >> 1) + bval;
        end else begin
            y.res = x.res >> 1;
        end
        return y;
    endfunction

    logic signed [31:0] sq_q, sq_d;
    logic [30:0]        r_sq_q, r_sq_d;
    t_sq                r_st [0:8];
    t_sq                n_st [1:8];

    always_comb begin
        sq_q = i_vq * i_vq;
        sq_d = i_vd * i_vd;
        for (int j = 0; j < 8; j++) begin
            n_st[j+1] = sq_step(sq_step(r_st[j], 2 * j), 2 * j + 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_sq_q <= 31'(unsigned'(sq_q));
            r_sq_d <= 31'(unsigned'(sq_d));
        end
        if (i_en[1]) begin
            r_st[0].n   <= 32'(r_sq_q) + 32'(r_sq_d);
            r_st[0].res <= '0;
        end
        for (int j = 1; j <= 8; j++) begin
            if (i_en[j+1]) begin
                r_st[j] <= n_st[j];
            end
        end
    end

    assign o_mag = r_st[8].res[15:0];

endmodule

[rtl/svpm_mix.sv]
// Inverse Park, third-harmonic injection, inverse Clarke and rounding to 1/256 V.
module svpm_mix (
    input  logic                            i_clk,
    input  logic [svpm_pkg::MIX_STAGES-1:0] i_en,
    input  svpm_pkg::t_cmd                  i_vq,
    input  svpm_pkg::t_cmd                  i_vd,
    input  svpm_pkg::t_q15                  i_sn,
    input  svpm_pkg::t_q15                  i_cs,
    input  svpm_pkg::t_q15                  i_s3,
    input  logic [15:0]                     i_mag,
    input  svpm_pkg::t_u16                  i_supply,
    output svpm_pkg::t_volt                 o_va,
    output svpm_pkg::t_volt                 o_vb,
    output svpm_pkg::t_volt                 o_vc
);
    import svpm_pkg::*;

    // {negative, (|n| + 3 * 2^31) / 2^32 clamped to 19 bits}
    function automatic logic [19:0] scale(logic signed [55:0] n);
        logic [55:0] m;
        logic [23:0] xx;
        m  = n[55] ? 56'(-n) : 56'(n);
        m  = m + (56'd3 << 31);
        xx = 24'(m >> 32);
        if (xx >= 24'd524288) begin
            xx = 24'd524287;
        end
        return {n[55], xx[18:0]};
    endfunction

    function automatic t_volt finish(logic [19:0] nx);
        logic [38:0]        pr;
        logic signed [18:0] q;
        pr = 39'(nx[18:0]) * 39'(DIV3_RECIP);
        q  = $signed(19'(pr >> 21));
        if (nx[19]) begin
            q = -q;
        end
        if (q > 19'sd131071) begin
            q = 19'sd131071;
        end else if (q < -19'sd131072) begin
            q = -19'sd131072;
        end
        return t_volt'(q);
    endfunction

    logic signed [32:0] r_pdc, r_pqs, r_pqc, r_pds;
    t_q15               r_s3a, r_s3b;
    logic signed [33:0] r_alpha, r_beta, r_alpha_c, r_ms;
    logic signed [51:0] r_bs;
    logic signed [55:0] r_na, r_nb, r_nc;
    logic [19:0]        r_xa, r_xb, r_xc;
    t_volt              r_va, r_vb, r_vc;

    logic signed [55:0] a56, ms56, bs56, off, kk, na, nb, nc;

    always_comb begin
        a56  = 56'(r_alpha_c);
        ms56 = 56'(r_ms);
        bs56 = 56'(r_bs);
        off  = $signed((56'(i_supply) * 56'd3) << 31);
        kk   = (a56 * 3 + ms56) <<< 16;
        na   = ((a56 * 6 - ms56) <<< 16) + off;
        nb   = bs56 * 3 - kk + off;
        nc   = -(bs56 * 3) - kk + off;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_pdc <= i_vd * i_cs;
            r_pqs <= i_vq * i_sn;
            r_pqc <= i_vq * i_cs;
            r_pds <= i_vd * i_sn;
            r_s3a <= i_s3;
        end
        if (i_en[1]) begin
            r_alpha <= 34'(r_pdc) - 34'(r_pqs);
            r_beta  <= 34'(r_pqc) + 34'(r_pds);
            r_s3b   <= r_s3a;
        end
        if (i_en[2]) begin
            r_bs      <= r_beta * SQRT3_Q16;
            r_ms      <= 34'($signed({1'b0, i_mag})) * 34'(r_s3b);
            r_alpha_c <= r_alpha;
        end
        if (i_en[3]) begin
            r_na <= na;
            r_nb <= nb;
            r_nc <= nc;
        end
        if (i_en[4]) begin
            r_xa <= scale(r_na);
            r_xb <= scale(r_nb);
            r_xc <= scale(r_nc);
        end
        if (i_en[5]) begin
            r_va <= finish(r_xa);
            r_vb <= finish(r_xb);
            r_vc <= finish(r_xc);
        end
    end

    assign o_va = r_va;
    assign o_vb = r_vb;
    assign o_vc = r_vc;

endmodule

[rtl/svpm_duty.sv]
// Pipelined compare count: floor(period * v / supply), saturated to 0..period.
module svpm_duty (
    input  logic                             i_clk,
    input  logic [svpm_pkg::DUTY_STAGES-1:0] i_en,
    input  svpm_pkg::t_volt                  i_v,
    input  svpm_pkg::t_u16                   i_supply,
    input  svpm_pkg::t_u16                   i_period,
    output svpm_pkg::t_u16                   o_duty
);
    import svpm_pkg::*;

    logic [15:0] r_rem  [0:8];
    logic [15:0] r_low  [0:8];
    logic        r_zero [0:8];
    logic        r_full [0:8];
    logic [15:0] n_rem  [1:8];
    logic [15:0] n_low  [1:8];

    logic        zero, full;
    logic [31:0] prod;
    logic [16:0] t;
    logic [15:0] rem, low;

    always_comb begin
        zero = i_v[17] || (i_v == '0);
        full = !zero && (i_v[16:0] >= 17'(i_supply));
        prod = 32'(i_period) * 32'(i_v[15:0]);
        for (int j = 0; j < 8; j++) begin
            rem = r_rem[j];
            low = r_low[j];
            for (int b = 0; b < 2; b++) begin
                t = {rem, low[15]};
                if (t >= 17'(i_supply)) begin
                    rem = 16'(t - 17'(i_supply));
                    low = {low[14:0], 1'b1};
                end else begin
                    rem = t[15:0];
                    low = {low[14:0], 1'b0};
                end
            end
            n_rem[j+1] = rem;
            n_low[j+1] = low;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_rem[0]  <= prod[31:16];
            r_low[0]  <= prod[15:0];
            r_zero[0] <= zero;
            r_full[0] <= full;
        end
        for (int j = 1; j <= 8; j++) begin
            if (i_en[j]) begin
                r_rem[j]  <= n_rem[j];
                r_low[j]  <= n_low[j];
                r_zero[j] <= r_zero[j-1];
                r_full[j] <= r_full[j-1];
            end
        end
    end

    assign o_duty = r_zero[8] ? '0 : (r_full[8] ? i_period : r_low[8]);

endmodule

[rtl/svpwm_phase_duty_modulator_core.sv]
// Phase duty modulator: dq command and angle in, three phase voltages and duties out.
//
// Input stream s_*: one request per accepted beat holds volt_q, volt_d and the
// electrical angle; the low ANGLE_BITS bits of the angle are one turn.
// Output stream m_*: one result per request, in order, with the three phase
// voltages (1/256 V, half-supply offset) and the three PWM compare counts.
// Config channel i_cfg_*: index 0 is the supply voltage, index 1 the PWM
// period; other indexes are dropped. Write only while no request is in flight.
// Throughput: one request per cycle unless m_tready low holds a full pipe.
// The pipe holds the sine polynomial (8 stages), the square root (two bits per
// stage), the scaling multiplies and the 16-bit duty divider (two bits per
// stage). Each stage carries its own valid bit and moves when it is empty or
// the next stage moves, so bubbles close up under stall.
// m_tready low holds the result and fills the pipe; s_tready drops only when
// every stage holds a request.
// Reset clears all valid bits and loads supply 3072 and period 1000.
module svpwm_phase_duty_modulator_core #(
    parameter int ANGLE_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,   // volt_q[15:0], volt_d[31:16], elec_angle[47:32]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // phase_a[17:0], phase_b[35:18], phase_c[53:36],
                                    // duty_a[69:54], duty_b[85:70], duty_c[101:86]
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [7:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_data
);
    import svpm_pkg::*;

    localparam int MIX_BASE  = SIN_STAGES + 1;
    localparam int DUTY_BASE = MIX_BASE + MIX_STAGES;
    localparam int NS        = DUTY_BASE + DUTY_STAGES;
    localparam logic [31:0] ANGLE_MASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);

    logic [NS-1:0] r_vld, n_vld, en, prev_vld;
    t_u16          r_supply, r_period;

    t_cmd          r_vq0, r_vd0;
    logic [31:0]   r_u0;
    t_cmd          r_vq_d [1:SIN_STAGES];
    t_cmd          r_vd_d [1:SIN_STAGES];
    t_volt         r_va_d [DUTY_BASE:NS-1];
    t_volt         r_vb_d [DUTY_BASE:NS-1];
    t_volt         r_vc_d [DUTY_BASE:NS-1];

    t_q15          sn, cs, s3;
    logic [15:0]   mag;
    t_volt         va, vb, vc;
    t_u16          duty_a, duty_b, duty_c;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_supply <= SUPPLY_RST;
            r_period <= PERIOD_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SUPPLY: r_supply <= i_cfg_data;
                REG_PERIOD: r_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage k moves when any stage at or after it is empty, or the sink takes
    always_comb begin
        prev_vld = {r_vld[NS-2:0], s_tvalid};
        for (int k = 0; k < NS; k++) begin
            en[k]    = m_tready || (((~r_vld) >> k) != '0);
            n_vld[k] = en[k] ? prev_vld[k] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = r_vld[NS-1];

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_vq0 <= s_tdata[15:0];
            r_vd0 <= s_tdata[31:16];
            r_u0  <= (32'(s_tdata[47:32]) & ANGLE_MASK) << (32 - ANGLE_BITS);
        end
        if (en[1]) begin
            r_vq_d[1] <= r_vq0;
            r_vd_d[1] <= r_vd0;
        end
        for (int k = 2; k <= SIN_STAGES; k++) begin
            if (en[k]) begin
                r_vq_d[k] <= r_vq_d[k-1];
                r_vd_d[k] <= r_vd_d[k-1];
            end
        end
        if (en[DUTY_BASE]) begin
            r_va_d[DUTY_BASE] <= va;
            r_vb_d[DUTY_BASE] <= vb;
            r_vc_d[DUTY_BASE] <= vc;
        end
        for (int k = DUTY_BASE + 1; k < NS; k++) begin
            if (en[k]) begin
                r_va_d[k] <= r_va_d[k-1];
                r_vb_d[k] <= r_vb_d[k-1];
                r_vc_d[k] <= r_vc_d[k-1];
            end
        end
    end

    svpm_sine u_sin (
        .i_clk  (i_clk),
        .i_en   (en[SIN_STAGES:1]),
        .i_turn (r_u0),
        .o_sine (sn)
    );

    svpm_sine u_cos (
        .i_clk  (i_clk),
        .i_en   (en[SIN_STAGES:1]),
        .i_turn (r_u0 + 32'h4000_0000),
        .o_sine (cs)
    );

    svpm_sine u_sin3 (
        .i_clk  (i_clk),
        .i_en   (en[SIN_STAGES:1]),
        .i_turn (r_u0 + {r_u0[30:0], 1'b0}),
        .o_sine (s3)
    );

    svpm_isqrt u_mag (
        .i_clk (i_clk),
        .i_en  (en[SQRT_STAGES:1]),
        .i_vq  (r_vq0),
        .i_vd  (r_vd0),
        .o_mag (mag)
    );

    svpm_mix u_mix (
        .i_clk    (i_clk),
        .i_en     (en[DUTY_BASE-1:MIX_BASE]),
        .i_vq     (r_vq_d[SIN_STAGES]),
        .i_vd     (r_vd_d[SIN_STAGES]),
        .i_sn     (sn),
        .i_cs     (cs),
        .i_s3     (s3),
        .i_mag    (mag),
        .i_supply (r_supply),
        .o_va     (va),
        .o_vb     (vb),
        .o_vc     (vc)
    );

    svpm_duty u_duty_a (
        .i_clk    (i_clk),
        .i_en     (en[NS-1:DUTY_BASE]),
        .i_v      (va),
        .i_supply (r_supply),
        .i_period (r_period),
        .o_duty   (duty_a)
    );

    svpm_duty u_duty_b (
        .i_clk    (i_clk),
        .i_en     (en[NS-1:DUTY_BASE]),
        .i_v      (vb),
        .i_supply (r_supply),
        .i_period (r_period),
        .o_duty   (duty_b)
    );

    svpm_duty u_duty_c (
        .i_clk    (i_clk),
        .i_en     (en[NS-1:DUTY_BASE]),
        .i_v      (vc),
        .i_supply (r_supply),
        .i_period (r_period),
        .o_duty   (duty_c)
    );

    assign m_tdata = {2'b00, duty_c, duty_b, duty_a,
                      r_vc_d[NS-1], r_vb_d[NS-1], r_va_d[NS-1]};

endmodule

[rtl/svpm_checker.sv]
// Port-level checks of the phase duty modulator, bound to the top level.
module svpm_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [103:0] m_tdata,
    input logic         i_cfg_valid,
    input logic         o_cfg_ready,
    input logic [7:0]   i_cfg_index,
    input logic [15:0]  i_cfg_data
);
    import svpm_pkg::*;

    t_u16 r_period;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RST;
        end else if (i_cfg_valid && o_cfg_ready && i_cfg_index == REG_PERIOD) begin
            r_period <= i_cfg_data;
        end
    end

    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tready |-> s_tready)
        else $error("input blocked while output drains");

    a_neg_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tdata[17] || m_tdata[17:0] == '0) |-> m_tdata[69:54] == '0)
        else $error("nonzero duty for non-positive phase voltage");

    a_duty_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> m_tdata[69:54] <= r_period && m_tdata[85:70] <= r_period
                     && m_tdata[101:86] <= r_period)
        else $error("duty above period");

endmodule

bind svpwm_phase_duty_modulator_core svpm_checker u_svpm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .s_tready    (s_tready),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready),
    .i_cfg_index (i_cfg_index),
    .i_cfg_data  (i_cfg_data)
);

[dv/tb_svpwm_phase_duty_modulator_core.sv]
// Self-checking testbench for the phase duty modulator core with random stream idling.
module tb_svpwm_phase_duty_modulator_core;
    import svpm_pkg::*;

    localparam int ANGLE_W   = 16;
    localparam int LIMIT_CYC = 400000;

    typedef struct packed {
        logic [15:0]        duty_c;
        logic [15:0]        duty_b;
        logic [15:0]        duty_a;
        logic signed [17:0] ph_c;
        logic signed [17:0] ph_b;
        logic signed [17:0] ph_a;
    } t_phase_res;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [47:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [7:0]   i_cfg_index;
    logic [15:0]  i_cfg_data;

    longint     bus_mv;
    longint     pwm_top;
    t_phase_res pending_q[$];
    int         n_mismatch;
    int         n_results;
    int         n_requests;
    int         n_cycles;
    int         hold_cycles;
    bit         rx_idle_en;

    svpwm_phase_duty_modulator_core #(.ANGLE_BITS(ANGLE_W)) dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // truncated polynomial sine, Q15, angle as 32-bit turn fraction
    function automatic longint sin_q15(logic [31:0] u);
        logic [63:0] f, x2, p, s, r;
        f = {48'd0, u[29:14]};
        if (u[30]) f = 64'd65536 - f;
        x2 = (f * f) >> 16;
        p = SIN_C9;
        p = SIN_C7 - ((p * x2) >> 16);
        p = SIN_C5 - ((p * x2) >> 16);
        p = SIN_C3 - ((p * x2) >> 16);
        p = SIN_C1 - ((p * x2) >> 16);
        s = (p * f) >> 16;
        r = (s + 64'd4096) >> 13;
        if (r > 64'd32768) r = 64'd32768;
        return u[31] ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint mag_floor(longint n);
        longint lo, hi, mid;
        lo = 0;
        hi = 46341;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid <= n) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic longint volt_round(longint num, longint den);
        longint v;
        if (num >= 0) v = (num + den / 2) / den;
        else v = -((-num + den / 2) / den);
        if (v > 131071) v = 131071;
        if (v < -131072) v = -131072;
        return v;
    endfunction

    function automatic logic [15:0] duty_count(longint v);
        if (v <= 0) return 16'd0;
        if (v >= bus_mv) return pwm_top[15:0];
        return 16'((pwm_top * v) / bus_mv);
    endfunction

    function automatic t_phase_res modulate(logic [47:0] cmd);
        longint     vq, vd, sn, cs, s3, al, be, inj, off, den, va, vb, vc;
        logic [31:0] u;
        t_phase_res r;
        vq = longint'($signed(cmd[15:0]));
        vd = longint'($signed(cmd[31:16]));
        u = {cmd[47:32], 16'd0};
        sn = sin_q15(u);
        cs = sin_q15(u + 32'h4000_0000);
        s3 = sin_q15(u * 32'd3);
        al = vd * cs - vq * sn;
        be = vq * cs + vd * sn;
        inj = mag_floor(vq * vq + vd * vd) * s3 * 65536;
        off = bus_mv * 3 * 64'sd2147483648;
        den = 6 * 64'sd2147483648;
        va = volt_round(6 * 65536 * al - inj + off, den);
        vb = volt_round(3 * (be * 113512 - al * 65536) - inj + off, den);
        vc = volt_round(-3 * (al * 65536 + be * 113512) - inj + off, den);
        r.ph_a = 18'(va);
        r.ph_b = 18'(vb);
        r.ph_c = 18'(vc);
        r.duty_a = duty_count(va);
        r.duty_b = duty_count(vb);
        r.duty_c = duty_count(vc);
        return r;
    endfunction

    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 55) return 0;
        if (k < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // valid stays high into the next request when no gap follows
    task automatic send_cmd(logic [15:0] vq, logic [15:0] vd, logic [15:0] ang,
                            bit idle_en);
        int g;
        g = idle_en ? gap_len() : 0;
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ang, vd, vq};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        pending_q.push_back(modulate({ang, vd, vq}));
        n_requests++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == REG_SUPPLY) bus_mv = val;
        else if (idx == REG_PERIOD) pwm_top = val;
        @(posedge i_clk);
    endtask

    task automatic write_bad_index();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= 8'hA5;
        i_cfg_data  <= 16'h0001;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_random(int n, bit idle_en);
        logic [15:0] vq, vd;
        for (int i = 0; i < n; i++) begin
            vq = 16'($urandom);
            vd = 16'($urandom);
            if ($urandom_range(0, 3) == 0) vq = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            if ($urandom_range(0, 3) == 0) vd = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            send_cmd(vq, vd, 16'($urandom), idle_en);
        end
    endtask

    task automatic test_directed();
        logic [15:0] angs[8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                                 16'hFFFF, 16'h2AAB, 16'h1555, 16'h0001};
        send_cmd(16'h0000, 16'h0000, 16'h0000, 1'b0);
        foreach (angs[i]) send_cmd(16'h7FFF, 16'h8000, angs[i], 1'b0);
        foreach (angs[i]) send_cmd(16'h8000, 16'h7FFF, angs[i], 1'b0);
        send_cmd(16'h8000, 16'h8000, 16'h5555, 1'b0);
        send_cmd(16'h7FFF, 16'h7FFF, 16'hAAAA, 1'b0);
        send_cmd(16'h0100, 16'hFF00, 16'h1234, 1'b0);
        send_cmd(16'h0000, 16'h0400, 16'h0000, 1'b0);
        drain();
    endtask

    task automatic test_config_sweep();
        logic [15:0] sup[5] = '{16'd1, 16'd65535, 16'd0, 16'd500, 16'd3072};
        logic [15:0] per[5] = '{16'd65535, 16'd1, 16'd777, 16'd0, 16'd1000};
        foreach (sup[i]) begin
            write_reg(REG_SUPPLY, sup[i]);
            write_reg(REG_PERIOD, per[i]);
            write_bad_index();
            send_random(40, 1'b1);
            drain();
        end
    endtask

    task automatic test_backpressure();
        fork
            begin
                rx_idle_en = 1'b0;
                @(posedge i_clk);
                m_tready <= 1'b0;
                hold_cycles = 0;
                while (hold_cycles < 80) begin
                    @(posedge i_clk);
                    hold_cycles++;
                end
                m_tready <= 1'b1;
                @(posedge i_clk);
                rx_idle_en = 1'b1;
            end
            send_random(60, 1'b0);
        join
        drain();
    endtask

    task automatic test_random_stream();
        write_reg(REG_SUPPLY, 16'($urandom_range(1, 65535)));
        write_reg(REG_PERIOD, 16'($urandom_range(1, 65535)));
        send_random(350, 1'b1);
        send_random(100, 1'b0);
        drain();
        write_reg(REG_SUPPLY, 16'd3072);
        write_reg(REG_PERIOD, 16'd1000);
        send_random(200, 1'b1);
        drain();
    endtask

    // receiver stalls
    initial begin
        m_tready = 1'b0;
        rx_idle_en = 1'b1;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (rx_idle_en) m_tready <= ($urandom_range(0, 9) < 7) ? 1'b1 : 1'b0;
        end
    end

    // result checker
    initial begin
        t_phase_res got, want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_tvalid && m_tready) begin
                got = t_phase_res'(m_tdata[101:0]);
                n_results++;
                if (pending_q.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10) $display("unexpected result %h", m_tdata);
                end else begin
                    want = pending_q.pop_front();
                    if (got !== want) begin
                        n_mismatch++;
                        if (n_mismatch <= 10)
                            $display({"mismatch: exp a=%0d b=%0d c=%0d da=%0d db=%0d dc=%0d",
                                      " | got a=%0d b=%0d c=%0d da=%0d db=%0d dc=%0d"},
                                want.ph_a, want.ph_b, want.ph_c, want.duty_a, want.duty_b,
                                want.duty_c, got.ph_a, got.ph_b, got.ph_c, got.duty_a,
                                got.duty_b, got.duty_c);
                    end
                end
            end
        end
    end

    // watchdog
    initial begin
        n_cycles = 0;
        forever begin
            @(posedge i_clk);
            n_cycles++;
            if (n_cycles >= LIMIT_CYC) begin
                $display("timeout with %0d results outstanding", pending_q.size());
                $display("tb_svpwm_phase_duty_modulator_core: FAIL");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        bus_mv      = SUPPLY_RST;
        pwm_top     = PERIOD_RST;
        n_mismatch  = 0;
        n_results   = 0;
        n_requests  = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_config_sweep();
        test_backpressure();
        test_random_stream();
        if (pending_q.size() != 0) n_mismatch += pending_q.size();
        $display("covered %0d requests / %0d results: field extremes, quadrant angles,",
                 n_requests, n_results);
        $display("supply/period extremes incl. zero, dropped index, full-pipe stall");
        if (n_mismatch == 0) begin
            $display("tb_svpwm_phase_duty_modulator_core: PASS");
        end else begin
            $display("tb_svpwm_phase_duty_modulator_core: FAIL");
        end
        $finish;
    end
endmodule

[files.f]
rtl/svpm_pkg.sv
rtl/svpm_sine.sv
rtl/svpm_isqrt.sv
rtl/svpm_mix.sv
rtl/svpm_duty.sv
rtl/svpwm_phase_duty_modulator_core.sv
rtl/svpm_checker.sv
dv/tb_svpwm_phase_duty_modulator_core.sv
